### rtl/kdq_pkg.sv
// kdq_pkg: shared types and constants for the keyed deque with delete
// used by kdq_ram and keyed_deque_with_delete; no dependencies
package kdq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;
	localparam int KEY_W = 32;
	localparam int PAY_W = 32;

	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		FN_PUSH_BACK  = 2'd0,
		FN_PUSH_FRONT = 2'd1,
		FN_POP_FRONT  = 2'd2,
		FN_DELETE     = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_FRONT_RD,
		ST_FRONT_OUT
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} record_t;

	typedef struct packed {
		logic    we;
		idx_t    waddr;
		record_t wdata;
		idx_t    raddr;
	} ram_req_t;

	// next slot round the ring
	function automatic idx_t slot_inc(idx_t p);
		return (p == LAST_IDX) ? '0 : idx_t'(p + 1'b1);
	endfunction

	// previous slot round the ring
	function automatic idx_t slot_dec(idx_t p);
		return (p == '0) ? LAST_IDX : idx_t'(p - 1'b1);
	endfunction

endpackage

### rtl/kdq_ram.sv
// kdq_ram: record storage, one write port and one read port with registered read data
// depends on kdq_pkg
module kdq_ram (
	input  logic              clk,
	input  kdq_pkg::ram_req_t req,
	output kdq_pkg::record_t  rdata
);
	import kdq_pkg::*;

	record_t mem_q [DEPTH];
	record_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata_q <= mem_q[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/keyed_deque_with_delete.sv
// keyed_deque_with_delete: top level, sequencer and ring pointers around one record memory
// depends on kdq_pkg and kdq_ram
//
// An ordered ring of up to DEPTH records (32-bit key, 32-bit payload). An item is taken when
// start is high and busy is low; busy then stays high until the result has gone out. The
// result is shown for one cycle with done high and cannot be held off, so the receiver must
// take it then. Push back, push front and pop pass through the execute, front-read and
// front-output states. Delete walks the records through the single memory read port: a
// read and a compare state per record compared, a read and a write state per record moved
// up to close the gap, the memory port being the limit. No clearing pass after reset.
module keyed_deque_with_delete (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                func,
	input  logic [kdq_pkg::KEY_W-1:0] record_key,
	input  logic [kdq_pkg::PAY_W-1:0] record_payload,
	output logic                      done,
	output logic                      found,
	output logic                      push_dropped,
	output logic                      is_empty,
	output logic [kdq_pkg::KEY_W-1:0] front_key,
	output logic [kdq_pkg::PAY_W-1:0] front_payload
);
	import kdq_pkg::*;

	state_t  state_q, state_d;
	func_t   func_q;
	record_t rec_q;
	idx_t    head_q;
	cnt_t    occ_q;
	cnt_t    pos_q;
	idx_t    ptr_q;
	logic    found_q;
	logic    dropped_q;

	ram_req_t req;
	record_t  rdata;

	logic [SUM_W-1:0] tail_sum;
	idx_t             tail_slot;
	logic             full;
	logic             more_after;
	logic             more_after_next;
	logic             key_hit;

	kdq_ram u_ram (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign tail_sum  = SUM_W'(head_q) + SUM_W'(occ_q);
	assign tail_slot = (tail_sum >= DEPTH_SUM) ? idx_t'(tail_sum - DEPTH_SUM) : idx_t'(tail_sum);
	assign full      = (occ_q >= DEPTH_CNT);
	assign key_hit   = (rdata.key == rec_q.key);
	// a record still follows position pos (or pos+1) that has to move up
	assign more_after      = ({1'b0, pos_q} + 1'b1) < {1'b0, occ_q};
	assign more_after_next = ({1'b0, pos_q} + 2'd2) < {1'b0, occ_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.we    = 1'b0;
		req.waddr = ptr_q;
		req.wdata = rdata;
		req.raddr = ptr_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (func_q)
					FN_PUSH_BACK: begin
						req.we    = !full;
						req.waddr = tail_slot;
						req.wdata = rec_q;
						state_d   = ST_FRONT_RD;
					end
					FN_PUSH_FRONT: begin
						req.we    = !full;
						req.waddr = slot_dec(head_q);
						req.wdata = rec_q;
						state_d   = ST_FRONT_RD;
					end
					FN_POP_FRONT: begin
						state_d = ST_FRONT_RD;
					end
					FN_DELETE: begin
						state_d = (occ_q != '0) ? ST_SCAN_RD : ST_FRONT_RD;
					end
				endcase
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CMP;
			end
			ST_SCAN_CMP: begin
				if (key_hit) begin
					state_d = more_after ? ST_SHIFT_RD : ST_FRONT_RD;
				end else begin
					state_d = more_after ? ST_SCAN_RD : ST_FRONT_RD;
				end
			end
			ST_SHIFT_RD: begin
				req.raddr = slot_inc(ptr_q);
				state_d   = ST_SHIFT_WR;
			end
			ST_SHIFT_WR: begin
				req.we    = 1'b1;
				req.waddr = ptr_q;
				req.wdata = rdata;
				state_d   = more_after_next ? ST_SHIFT_RD : ST_FRONT_RD;
			end
			ST_FRONT_RD: begin
				req.raddr = head_q;
				state_d   = ST_FRONT_OUT;
			end
			ST_FRONT_OUT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			occ_q     <= '0;
			pos_q     <= '0;
			ptr_q     <= '0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
			func_q    <= FN_PUSH_BACK;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						func_q    <= func_t'(func);
						found_q   <= 1'b0;
						dropped_q <= 1'b0;
						pos_q     <= '0;
						ptr_q     <= head_q;
					end
				end
				ST_EXEC: begin
					unique case (func_q)
						FN_PUSH_BACK: begin
							if (full) begin
								dropped_q <= 1'b1;
							end else begin
								occ_q <= cnt_t'(occ_q + 1'b1);
							end
						end
						FN_PUSH_FRONT: begin
							if (full) begin
								dropped_q <= 1'b1;
							end else begin
								head_q <= slot_dec(head_q);
								occ_q  <= cnt_t'(occ_q + 1'b1);
							end
						end
						FN_POP_FRONT: begin
							if (occ_q != '0) begin
								head_q <= slot_inc(head_q);
								occ_q  <= cnt_t'(occ_q - 1'b1);
							end
						end
						FN_DELETE: begin
						end
					endcase
				end
				ST_SCAN_CMP: begin
					if (key_hit) begin
						found_q <= 1'b1;
						if (!more_after) begin
							occ_q <= cnt_t'(occ_q - 1'b1);
						end
					end else if (more_after) begin
						pos_q <= cnt_t'(pos_q + 1'b1);
						ptr_q <= slot_inc(ptr_q);
					end
				end
				ST_SHIFT_WR: begin
					pos_q <= cnt_t'(pos_q + 1'b1);
					ptr_q <= slot_inc(ptr_q);
					if (!more_after_next) begin
						occ_q <= cnt_t'(occ_q - 1'b1);
					end
				end
				ST_SCAN_RD, ST_SHIFT_RD, ST_FRONT_RD, ST_FRONT_OUT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// item register for the key and payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			rec_q.key     <= record_key;
			rec_q.payload <= record_payload;
		end
	end

	assign busy          = (state_q != ST_IDLE);
	assign done          = (state_q == ST_FRONT_OUT);
	assign found         = found_q;
	assign push_dropped  = dropped_q;
	assign is_empty      = (occ_q == '0);
	assign front_key     = is_empty ? '0 : rdata.key;
	assign front_payload = is_empty ? '0 : rdata.payload;

endmodule

### sim/tb_keyed_deque_with_delete.sv
// tb_keyed_deque_with_delete: self-checking bench for the keyed deque with delete
// depends on kdq_pkg and the keyed_deque_with_delete rtl; a queue-based record list
// predicts every result, and a monitor compares each done strobe against it
module tb_keyed_deque_with_delete;
	import kdq_pkg::*;

	typedef struct packed {
		logic             found;
		logic             dropped;
		logic             empty;
		logic [KEY_W-1:0] fkey;
		logic [PAY_W-1:0] fpay;
	} outcome_t;

	class deque_scoreboard;
		record_t  held[$];
		outcome_t due[$];
		int       errors;

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("t=%0t %s: got %h, want %h", $realtime, what, got, want);
			errors++;
		endtask

		// apply one accepted item to the record list and queue its outcome
		function void note(func_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
			outcome_t o;
			record_t  r;
			int       hit;
			o = '0;
			r.key = k;
			r.payload = p;
			hit = -1;
			case (op)
				FN_PUSH_BACK, FN_PUSH_FRONT: begin
					if (held.size() >= DEPTH)
						o.dropped = 1'b1;
					else if (op == FN_PUSH_BACK)
						held.push_back(r);
					else
						held.push_front(r);
				end
				FN_POP_FRONT: begin
					if (held.size() != 0)
						void'(held.pop_front());
				end
				default: begin
					for (int i = 0; i < held.size() && hit < 0; i++)
						if (held[i].key == k)
							hit = i;
					if (hit >= 0) begin
						held.delete(hit);
						o.found = 1'b1;
					end
				end
			endcase
			o.empty = (held.size() == 0);
			if (!o.empty) begin
				o.fkey = held[0].key;
				o.fpay = held[0].payload;
			end
			due.push_back(o);
		endfunction

		task check(outcome_t got);
			outcome_t want;
			if (due.size() == 0) begin
				report("result with nothing outstanding", 32'(got.found), 32'h0);
			end else begin
				want = due.pop_front();
				if (got.found !== want.found)
					report("found", 32'(got.found), 32'(want.found));
				if (got.dropped !== want.dropped)
					report("push_dropped", 32'(got.dropped), 32'(want.dropped));
				if (got.empty !== want.empty)
					report("is_empty", 32'(got.empty), 32'(want.empty));
				if (got.fkey !== want.fkey)
					report("front_key", got.fkey, want.fkey);
				if (got.fpay !== want.fpay)
					report("front_payload", got.fpay, want.fpay);
			end
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [1:0]       func;
	logic [KEY_W-1:0] record_key;
	logic [PAY_W-1:0] record_payload;
	logic             done;
	logic             found;
	logic             push_dropped;
	logic             is_empty;
	logic [KEY_W-1:0] front_key;
	logic [PAY_W-1:0] front_payload;

	deque_scoreboard sb;
	bit              idle_on;

	keyed_deque_with_delete dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .record_key(record_key), .record_payload(record_payload),
		.done(done), .found(found), .push_dropped(push_dropped), .is_empty(is_empty),
		.front_key(front_key), .front_payload(front_payload)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("keyed_deque_with_delete: mismatch");
		$finish;
	end

	// results cannot be held off, so every strobe is taken as it comes
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check({found, push_dropped, is_empty, front_key, front_payload});
	end

	task automatic send_item(func_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		if (idle_on) begin
			while ($urandom_range(99) < 28) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		start <= 1'b1;
		func <= op;
		record_key <= k;
		record_payload <= p;
		do @(posedge clk); while (busy);
		sb.note(op, k, p);
	endtask

	// small key pool so deletes hit and duplicate keys occur, with full-width keys now and then
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(4) == 0)
			return $urandom();
		return KEY_W'($urandom_range(9));
	endfunction

	initial begin
		int    r;
		bit    filling;
		func_t op;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_PUSH_BACK;
		record_key = '0;
		record_payload = '0;
		idle_on = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, field extremes, a missed delete and a front delete
		send_item(FN_POP_FRONT, 32'h0, 32'h0);
		send_item(FN_DELETE, 32'hFFFF_FFFF, 32'h0);
		send_item(FN_PUSH_BACK, 32'hFFFF_FFFF, 32'h0);
		send_item(FN_PUSH_FRONT, 32'h0, 32'hFFFF_FFFF);
		send_item(FN_DELETE, 32'h1234_5678, 32'hFFFF_FFFF);
		send_item(FN_DELETE, 32'h0, 32'h0);
		send_item(FN_POP_FRONT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// fill from both ends, then push into the full store both ways
		for (int i = 0; i < DEPTH; i++)
			send_item((i % 2) ? FN_PUSH_FRONT : FN_PUSH_BACK, KEY_W'(100 + i), $urandom());
		send_item(FN_PUSH_BACK, 32'hAAAA_5555, 32'h5555_AAAA);
		send_item(FN_PUSH_FRONT, 32'h5555_AAAA, 32'hAAAA_5555);
		send_item(FN_DELETE, KEY_W'(100 + DEPTH - 2), 32'h0);

		filling = 1'b1;
		for (int n = 0; n < 600; n++) begin
			if (n % 40 == 0)
				filling = ~filling;
			idle_on = !(n >= 200 && n < 350);
			r = $urandom_range(99);
			if (r < (filling ? 60 : 25))
				op = r[0] ? FN_PUSH_FRONT : FN_PUSH_BACK;
			else if (r < (filling ? 75 : 60))
				op = FN_POP_FRONT;
			else
				op = FN_DELETE;
			send_item(op, pick_key(), $urandom());
		end
		start <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);
		if (sb.due.size() != 0)
			sb.report("results never seen", 32'(sb.due.size()), 32'h0);
		if (sb.errors == 0)
			$display("keyed_deque_with_delete: match");
		else
			$display("keyed_deque_with_delete: mismatch");
		$finish;
	end

endmodule
